### rtl/rcr_pkg.sv
// Shared types and constants for the rectangle canvas rasterizer.
// Used by the controller, the datapath and the top level; depends on nothing.
package rcr_pkg;

	// Fixed-point layout of the rectangle fields (Q12.8) and the internal
	// bound width. It leaves room for x + w and for a column times one unit.
	localparam int FRAC = 8;
	localparam int COORD_W = 20;
	localparam int FIXW = 23;
	localparam logic signed [FIXW-1:0] ONE_UNIT = 23'sd256;

	localparam int CFG_W = 9;

	typedef enum logic [1:0] {
		KIND_DRAW  = 2'd0,
		KIND_READ  = 2'd1,
		KIND_CLEAR = 2'd2,
		KIND_NONE  = 2'd3
	} kind_e;

	typedef enum logic [1:0] {
		STAT_OK      = 2'd0,
		STAT_NEG     = 2'd1,
		STAT_OUTSIDE = 2'd2
	} stat_e;

	typedef enum logic [1:0] {
		CFG_WIDTH  = 2'd0,
		CFG_HEIGHT = 2'd1,
		CFG_BG     = 2'd2
	} cfg_idx_e;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_SCAN,
		S_READ,
		S_DONE
	} state_e;

	typedef struct packed {
		logic [1:0]                 kind;
		logic signed [COORD_W-1:0]  rect_x;
		logic signed [COORD_W-1:0]  rect_y;
		logic signed [COORD_W-1:0]  rect_width;
		logic signed [COORD_W-1:0]  rect_height;
		logic                       outline_only;
		logic [7:0]                 draw_char;
		logic [7:0]                 pixel_col;
		logic [7:0]                 pixel_row;
	} item_t;

	typedef struct packed {
		logic [7:0] pixel_char;
		logic [1:0] status;
	} result_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic setup;
		logic scan;
		logic rd;
		logic finish;
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [1:0] kind;
		logic       neg;
		logic       outside;
		logic       last;
	} dp_stat_t;

endpackage

### rtl/rcr_ctrl.sv
// Controller state machine of the rectangle canvas rasterizer.
// Depends on rcr_pkg; drives the datapath through rcr_pkg::ctrl_cmd_t.
module rcr_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  rcr_pkg::dp_stat_t    stat,
	output rcr_pkg::ctrl_cmd_t   cmd,
	output logic                 busy
);

	rcr_pkg::state_e state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rcr_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			rcr_pkg::S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d = rcr_pkg::S_DECODE;
				end
			end
			rcr_pkg::S_DECODE: begin
				if (stat.kind == rcr_pkg::KIND_CLEAR ||
				    (stat.kind == rcr_pkg::KIND_DRAW && !stat.neg)) begin
					cmd.setup = 1'b1;
					state_d = rcr_pkg::S_SCAN;
				end else if (stat.kind == rcr_pkg::KIND_READ && !stat.outside) begin
					cmd.rd = 1'b1;
					state_d = rcr_pkg::S_READ;
				end else begin
					state_d = rcr_pkg::S_DONE;
				end
			end
			rcr_pkg::S_SCAN: begin
				cmd.scan = 1'b1;
				if (stat.last) begin
					state_d = rcr_pkg::S_DONE;
				end
			end
			rcr_pkg::S_READ: begin
				state_d = rcr_pkg::S_DONE;
			end
			rcr_pkg::S_DONE: begin
				cmd.finish = 1'b1;
				state_d = rcr_pkg::S_IDLE;
			end
			default: begin
				state_d = rcr_pkg::S_IDLE;
			end
		endcase
	end

	assign busy = (state_q != rcr_pkg::S_IDLE);

endmodule

### rtl/rcr_datapath.sv
// Datapath of the rectangle canvas rasterizer: configuration registers,
// item latch, scan counters, coverage test, canvas memory and result register.
// Depends on rcr_pkg; sequenced by rcr_ctrl.
module rcr_datapath #(
	parameter int MAX_SIDE = 256
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [1:0]                    cfg_index,
	input  logic [rcr_pkg::CFG_W-1:0]     cfg_data,
	input  rcr_pkg::item_t                item,
	input  rcr_pkg::ctrl_cmd_t            cmd,
	output rcr_pkg::dp_stat_t             stat,
	output rcr_pkg::result_t              result,
	output logic                          done
);

	localparam int CW = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
	localparam int SW = ($clog2(MAX_SIDE + 1) > rcr_pkg::CFG_W) ?
		$clog2(MAX_SIDE + 1) : rcr_pkg::CFG_W;
	localparam int AW = 2 * CW;
	localparam int DEPTH = 2 ** AW;
	localparam int PADW = rcr_pkg::FIXW - CW - rcr_pkg::FRAC;

	logic [rcr_pkg::CFG_W-1:0] width_q, height_q;
	logic [7:0]                bg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 9'd256;
			height_q <= 9'd256;
			bg_q     <= 8'd32;
		end else if (cfg_we) begin
			case (cfg_index)
				rcr_pkg::CFG_WIDTH:  width_q  <= cfg_data;
				rcr_pkg::CFG_HEIGHT: height_q <= cfg_data;
				rcr_pkg::CFG_BG:     bg_q     <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// Effective canvas size: zero acts as one, anything above MAX_SIDE is clamped.
	logic [SW-1:0] wd, ht;
	logic [CW-1:0] wd_last, ht_last;

	always_comb begin
		if (width_q == '0) begin
			wd = SW'(1);
		end else if (SW'(width_q) > SW'(MAX_SIDE)) begin
			wd = SW'(MAX_SIDE);
		end else begin
			wd = SW'(width_q);
		end
		if (height_q == '0) begin
			ht = SW'(1);
		end else if (SW'(height_q) > SW'(MAX_SIDE)) begin
			ht = SW'(MAX_SIDE);
		end else begin
			ht = SW'(height_q);
		end
	end

	assign wd_last = CW'(wd - SW'(1));
	assign ht_last = CW'(ht - SW'(1));

	rcr_pkg::item_t item_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= item;
		end
	end

	logic [SW-1:0] rd_col, rd_row;
	logic          outside;

	assign rd_col  = SW'(item_q.pixel_col);
	assign rd_row  = SW'(item_q.pixel_row);
	assign outside = (rd_col >= wd) || (rd_row >= ht);

	// Rectangle bounds, registered once per draw so that each scan cycle
	// only compares.
	logic signed [rcr_pkg::FIXW-1:0] x0_q, x1_q, xw_q, xw1_q;
	logic signed [rcr_pkg::FIXW-1:0] y0_q, y1_q, yh_q, yh1_q;
	logic signed [rcr_pkg::FIXW-1:0] bx, by, bw, bh;

	assign bx = rcr_pkg::FIXW'(item_q.rect_x);
	assign by = rcr_pkg::FIXW'(item_q.rect_y);
	assign bw = rcr_pkg::FIXW'(item_q.rect_width);
	assign bh = rcr_pkg::FIXW'(item_q.rect_height);

	always_ff @(posedge clk) begin
		if (cmd.setup) begin
			x0_q  <= bx;
			x1_q  <= bx + rcr_pkg::ONE_UNIT;
			xw_q  <= bx + bw;
			xw1_q <= bx + bw - rcr_pkg::ONE_UNIT;
			y0_q  <= by;
			y1_q  <= by + rcr_pkg::ONE_UNIT;
			yh_q  <= by + bh;
			yh1_q <= by + bh - rcr_pkg::ONE_UNIT;
		end
	end

	logic [CW-1:0] col_q, row_q;
	logic          col_end, last;

	assign col_end = (col_q == wd_last);
	assign last    = col_end && (row_q == ht_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cmd.setup) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cmd.scan) begin
			if (col_end) begin
				col_q <= '0;
				row_q <= row_q + CW'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	logic signed [rcr_pkg::FIXW-1:0] px, py;
	logic covered, border, wr_en;
	logic is_clear;

	assign px = $signed({{PADW{1'b0}}, col_q, {rcr_pkg::FRAC{1'b0}}});
	assign py = $signed({{PADW{1'b0}}, row_q, {rcr_pkg::FRAC{1'b0}}});

	assign covered = (px >= x0_q) && (px <= xw_q) && (py >= y0_q) && (py <= yh_q);
	assign border  = (px < x1_q) || (px > xw1_q) || (py < y1_q) || (py > yh1_q);
	assign is_clear = (item_q.kind == rcr_pkg::KIND_CLEAR);
	assign wr_en = cmd.scan &&
		(is_clear || (covered && (!item_q.outline_only || border)));

	// Canvas: cell (col,row) sits at {row, col}. No reset; a clear sweeps it.
	logic [7:0]    canvas_mem [DEPTH];
	logic [AW-1:0] wr_addr, rd_addr;
	logic [7:0]    wr_data;
	logic [7:0]    rd_data_q;

	assign wr_addr = {row_q, col_q};
	assign rd_addr = {rd_row[CW-1:0], rd_col[CW-1:0]};
	assign wr_data = is_clear ? bg_q : item_q.draw_char;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			canvas_mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			rd_data_q <= canvas_mem[rd_addr];
		end
	end

	rcr_pkg::result_t result_q;
	logic             done_q;

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			if (item_q.kind == rcr_pkg::KIND_READ && !outside) begin
				result_q.pixel_char <= rd_data_q;
			end else begin
				result_q.pixel_char <= '0;
			end
			if (item_q.kind == rcr_pkg::KIND_DRAW &&
			    (item_q.rect_width[rcr_pkg::COORD_W-1] ||
			     item_q.rect_height[rcr_pkg::COORD_W-1])) begin
				result_q.status <= rcr_pkg::STAT_NEG;
			end else if (item_q.kind == rcr_pkg::KIND_READ && outside) begin
				result_q.status <= rcr_pkg::STAT_OUTSIDE;
			end else begin
				result_q.status <= rcr_pkg::STAT_OK;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.finish;
		end
	end

	assign stat.kind    = item_q.kind;
	assign stat.neg     = item_q.rect_width[rcr_pkg::COORD_W-1] ||
		item_q.rect_height[rcr_pkg::COORD_W-1];
	assign stat.outside = outside;
	assign stat.last    = last;

	assign result = result_q;
	assign done   = done_q;

endmodule

### rtl/rectangle_canvas_rasterizer.sv
// Rectangle canvas rasterizer, top level: a character canvas of up to
// MAX_SIDE by MAX_SIDE cells. A clear or a draw walks every cell of the
// configured W by H canvas, one cell per cycle through the single write port
// of the canvas memory. Busy spans the decode, scan and done states, decode,
// read and done for a read, and decode and done for a rejected draw
// (negative size), an outside read or an unused kind; done follows in the
// next cycle. A new item may be started in the same cycle as the result
// strobe. Every result is marked by done for exactly one cycle; the
// receiver cannot stall it. Read a cell only after the canvas has been
// cleared once. Configuration writes are taken at any edge with cfg_we high
// but belong in idle time. Depends on rcr_pkg, rcr_ctrl and rcr_datapath.
module rectangle_canvas_rasterizer #(
	parameter int MAX_SIDE = 256
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  rcr_pkg::item_t             item,
	output logic                       done,
	output rcr_pkg::result_t           result,
	input  logic                       cfg_we,
	input  logic [1:0]                 cfg_index,
	input  logic [rcr_pkg::CFG_W-1:0]  cfg_data
);

	rcr_pkg::ctrl_cmd_t cmd;
	rcr_pkg::dp_stat_t  stat;

	rcr_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	rcr_datapath #(
		.MAX_SIDE (MAX_SIDE)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.item      (item),
		.cmd       (cmd),
		.stat      (stat),
		.result    (result),
		.done      (done)
	);

	// The result strobe comes only after the controller has gone back to idle.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	// An accepted item makes the block busy in the next cycle.
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted item did not make the block busy");

	// One strobe per item, never two in a row.
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe lasted more than one cycle");

	// Only a successful read returns a character.
	a_char_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status != rcr_pkg::STAT_OK) |-> (result.pixel_char == 8'd0))
		else $error("error result carries a character");

endmodule

### test/rcr_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the rectangle canvas rasterizer. It watches the item, result and
// register write channels, keeps its own copy of the canvas and checks every result.
// Depends on rcr_pkg.
module rcr_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic                       busy,
	input  rcr_pkg::item_t             item,
	input  logic                       done,
	input  rcr_pkg::result_t           result,
	input  logic                       cfg_we,
	input  logic [1:0]                 cfg_index,
	input  logic [rcr_pkg::CFG_W-1:0]  cfg_data,
	output int                         fail_count,
	output int                         outstanding
);
	import rcr_pkg::*;

	localparam int SIDE = 256;
	localparam longint UNIT = 256;

	logic [7:0] cells [0:SIDE*SIDE-1];
	logic [CFG_W-1:0] width_reg;
	logic [CFG_W-1:0] height_reg;
	logic [7:0] bg_reg;
	result_t expected_results [$];

	function automatic int clamp_side(logic [CFG_W-1:0] v);
		if (v == 0)
			return 1;
		if (v > SIDE)
			return SIDE;
		return int'(v);
	endfunction

	// Applies one item to the local canvas and returns the result it should give.
	function automatic result_t rasterize_item(item_t it);
		result_t r;
		int wd;
		int ht;
		longint x, y, w, h, px, py;
		logic covered;
		logic on_border;
		r = '0;
		wd = clamp_side(width_reg);
		ht = clamp_side(height_reg);
		case (kind_e'(it.kind))
			KIND_CLEAR: begin
				for (int row = 0; row < ht; row++)
					for (int col = 0; col < wd; col++)
						cells[row*SIDE + col] = bg_reg;
			end
			KIND_READ: begin
				if (it.pixel_col >= wd || it.pixel_row >= ht)
					r.status = STAT_OUTSIDE;
				else
					r.pixel_char = cells[int'(it.pixel_row)*SIDE + int'(it.pixel_col)];
			end
			KIND_DRAW: begin
				x = $signed(it.rect_x);
				y = $signed(it.rect_y);
				w = $signed(it.rect_width);
				h = $signed(it.rect_height);
				if (w < 0 || h < 0) begin
					r.status = STAT_NEG;
				end else begin
					for (int row = 0; row < ht; row++) begin
						for (int col = 0; col < wd; col++) begin
							// Cell centers sit on whole units of the Q12.8 grid.
							px = col * UNIT;
							py = row * UNIT;
							covered = px >= x && px <= x + w && py >= y && py <= y + h;
							on_border = px < x + UNIT || px > x + w - UNIT ||
								py < y + UNIT || py > y + h - UNIT;
							if (covered && (!it.outline_only || on_border))
								cells[row*SIDE + col] = it.draw_char;
						end
					end
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			expected_results.delete();
			width_reg = 9'd256;
			height_reg = 9'd256;
			bg_reg = 8'd32;
			fail_count = 0;
			outstanding = 0;
		end else begin
			// The result of this edge belongs to an earlier transfer, so it is
			// matched before a new item is queued.
			if (done) begin
				if (expected_results.size() == 0) begin
					if (fail_count < 10)
						$display("unexpected result: pixel_char %0d status %0d",
							result.pixel_char, result.status);
					fail_count++;
				end else begin
					want = expected_results.pop_front();
					if (result.pixel_char !== want.pixel_char ||
						result.status !== want.status) begin
						if (fail_count < 10)
							$display("mismatch: pixel_char exp %0d got %0d, status exp %0d got %0d",
								want.pixel_char, result.pixel_char, want.status, result.status);
						fail_count++;
					end
				end
			end
			if (cfg_we) begin
				case (cfg_idx_e'(cfg_index))
					CFG_WIDTH:  width_reg = cfg_data;
					CFG_HEIGHT: height_reg = cfg_data;
					CFG_BG:     bg_reg = cfg_data[7:0];
					default: ;
				endcase
			end
			if (start && !busy)
				expected_results.push_back(rasterize_item(item));
			outstanding = expected_results.size();
		end
	end

endmodule

### test/testbench.sv
`timescale 1ns / 1ps
// Top of the rasterizer testbench: clock, reset, register setup and item stimulus.
// Prediction and comparison live in rcr_checker. Depends on rcr_pkg, rcr_checker
// and the rectangle_canvas_rasterizer RTL.
module testbench;
	import rcr_pkg::*;

	localparam int UNIT = 256;
	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int PHASE_ITEMS = 10;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	item_t item;
	logic done;
	result_t result;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;
	int fail_count;
	int outstanding;
	bit idle_on;
	int cur_wd;
	int cur_ht;

	rectangle_canvas_rasterizer dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.done(done),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	rcr_checker watch (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.done(done),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.fail_count(fail_count),
		.outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("[rectangle_canvas_rasterizer] ERROR");
		$finish;
	end

	// Called at a falling edge; returns at the falling edge after the transfer,
	// with start still high so that a following item can keep it there.
	task automatic push_item(input item_t it);
		while (idle_on && $urandom_range(99) < 38) begin
			start = 1'b0;
			@(negedge clk);
		end
		item = it;
		start = 1'b1;
		do @(posedge clk); while (busy);
		@(negedge clk);
	endtask

	// Holds off until every outstanding result has come back.
	task automatic settle();
		start = 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_idx_e idx, input int value);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = value[CFG_W-1:0];
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic set_canvas(input int wd, input int ht, input int bg);
		int wv;
		int hv;
		settle();
		write_reg(CFG_WIDTH, wd);
		write_reg(CFG_HEIGHT, ht);
		write_reg(CFG_BG, bg);
		// The registers keep only the low bits of what was written.
		wv = wd & 511;
		hv = ht & 511;
		cur_wd = (wv == 0) ? 1 : (wv > 256) ? 256 : wv;
		cur_ht = (hv == 0) ? 1 : (hv > 256) ? 256 : hv;
	endtask

	// Every field random, so that fields a kind ignores still toggle.
	function automatic item_t noise_item();
		logic [127:0] bits;
		bits = {$urandom, $urandom, $urandom, $urandom};
		return bits[$bits(item_t)-1:0];
	endfunction

	task automatic push_kind(input kind_e k);
		item_t it;
		it = noise_item();
		it.kind = k;
		push_item(it);
	endtask

	task automatic draw_rect(input int x, input int y, input int w, input int h,
		input bit outline, input logic [7:0] ch);
		item_t it;
		it = noise_item();
		it.kind = KIND_DRAW;
		it.rect_x = x[COORD_W-1:0];
		it.rect_y = y[COORD_W-1:0];
		it.rect_width = w[COORD_W-1:0];
		it.rect_height = h[COORD_W-1:0];
		it.outline_only = outline;
		it.draw_char = ch;
		push_item(it);
	endtask

	task automatic read_cell(input int col, input int row);
		item_t it;
		it = noise_item();
		it.kind = KIND_READ;
		it.pixel_col = col[7:0];
		it.pixel_row = row[7:0];
		push_item(it);
	endtask

	// Half rectangles, mostly on or near the canvas with some rejected sizes and
	// raw noise, then reads, clears and unused kinds.
	function automatic item_t random_item();
		item_t it;
		int pick;
		int x, y, w, h;
		it = noise_item();
		pick = $urandom_range(99);
		if (pick < 50) begin
			it.kind = KIND_DRAW;
			pick = $urandom_range(9);
			if (pick < 8) begin
				x = int'($urandom_range(0, (cur_wd + 3) * UNIT)) - 2 * UNIT;
				y = int'($urandom_range(0, (cur_ht + 3) * UNIT)) - 2 * UNIT;
				// Thin rectangles, at most two units on a side, mostly cover border cells.
				w = int'($urandom_range(0, (pick < 3) ? 2 * UNIT : (cur_wd + 1) * UNIT));
				h = int'($urandom_range(0, (pick < 3) ? 2 * UNIT : (cur_ht + 1) * UNIT));
				it.rect_x = x[COORD_W-1:0];
				it.rect_y = y[COORD_W-1:0];
				it.rect_width = w[COORD_W-1:0];
				it.rect_height = h[COORD_W-1:0];
			end else if (pick == 8) begin
				if ($urandom_range(1))
					it.rect_width[COORD_W-1] = 1'b1;
				else
					it.rect_height[COORD_W-1] = 1'b1;
			end
		end else if (pick < 85) begin
			it.kind = KIND_READ;
			if ($urandom_range(4) != 0) begin
				it.pixel_col = 8'($urandom_range(0, cur_wd - 1));
				it.pixel_row = 8'($urandom_range(0, cur_ht - 1));
			end
		end else if (pick < 95) begin
			it.kind = KIND_CLEAR;
		end else begin
			it.kind = KIND_NONE;
		end
		return it;
	endfunction

	task automatic run_phase(input int wd, input int ht, input int bg);
		set_canvas(wd, ht, bg);
		push_kind(KIND_CLEAR);
		repeat (PHASE_ITEMS) push_item(random_item());
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		cfg_we = 1'b0;
		cfg_index = CFG_WIDTH;
		cfg_data = '0;
		idle_on = 1'b0;
		cur_wd = 256;
		cur_ht = 256;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// One clear at the reset size writes every cell, so no read can hit an
		// unwritten one later on.
		push_kind(KIND_CLEAR);
		draw_rect(-128, 100 * UNIT + 37, 200 * UNIT, 50 * UNIT + 200, 1'b1, "R");
		read_cell(0, 101);
		read_cell(255, 255);
		read_cell(199, 150);

		set_canvas(8, 6, 0);
		push_kind(KIND_CLEAR);
		draw_rect(-UNIT, -UNIT, 524287, 524287, 1'b0, 8'd1);
		draw_rect(-524288, -524288, 524287, 524287, 1'b0, 8'hFF);
		draw_rect(0, 0, 0, 0, 1'b0, "r");
		draw_rect(524287, 524287, 0, 0, 1'b0, 8'h00);
		draw_rect(UNIT + 1, UNIT, 3 * UNIT, 2 * UNIT - 1, 1'b1, 8'hAA);
		draw_rect(2 * UNIT, 0, 100, 5 * UNIT, 1'b1, "X");
		draw_rect(UNIT, UNIT, -1, 0, 1'b0, 8'h55);
		draw_rect(UNIT, UNIT, 0, -524288, 1'b1, 8'h55);
		push_kind(KIND_NONE);
		read_cell(0, 0);
		read_cell(7, 5);
		read_cell(3, 2);
		read_cell(8, 0);
		read_cell(0, 6);
		read_cell(255, 255);

		idle_on = 1'b1;
		run_phase(1, 1, 255);
		idle_on = 1'b0;
		run_phase(16, 16, $urandom_range(255));
		idle_on = 1'b1;
		run_phase(0, 5, $urandom_range(255));
		run_phase(511, 1, $urandom_range(255));
		run_phase(3, 300, $urandom_range(255));
		run_phase(12, 0, $urandom_range(255));
		run_phase(9, 12, $urandom_range(255));

		settle();
		repeat (8) @(negedge clk);
		if (fail_count == 0 && outstanding == 0)
			$display("[rectangle_canvas_rasterizer] OK");
		else
			$display("[rectangle_canvas_rasterizer] ERROR");
		$finish;
	end

endmodule

### sim.f
rtl/rcr_pkg.sv
rtl/rcr_ctrl.sv
rtl/rcr_datapath.sv
rtl/rectangle_canvas_rasterizer.sv
test/rcr_checker.sv
test/testbench.sv
